// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle whenever ante holds.
`define SPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: implication");

// Check that cons holds in the cycle after ante holds.
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

`else

`define SPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/spd_pkg.sv =====
package spd_pkg;

    // Frame layout
    localparam int PAYLOAD_LEN  = 18;
    localparam int CNT_W        = 5;
    localparam int SEEN_W       = 2;
    localparam int SYNC_LEN_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [7:0] SYNC_RESET = 8'd80;

    // Roof state codes
    localparam logic [7:0] ROOF_RAISING = 8'd1;
    localparam logic [7:0] ROOF_LOWERING = 8'd2;
    localparam logic [7:0] ROOF_RAISED  = 8'd3;
    localparam logic [7:0] ROOF_LOWERED = 8'd4;

    // Roof position in percent
    localparam logic [6:0] POS_RAISED = 7'd100;
    localparam logic [6:0] POS_MOVING = 7'd50;
    localparam logic [6:0] POS_OTHER  = 7'd0;

    // One payload byte on its way from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic [CNT_W-1:0] idx;
        logic             last;
    } t_entry;

    // One decoded status packet
    typedef struct packed {
        logic [31:0] current_bits;
        logic [31:0] supply5_bits;
        logic [31:0] supply12_bits;
        logic [7:0]  upper_limit_a;
        logic [7:0]  upper_limit_b;
        logic [7:0]  lower_limit_a;
        logic [7:0]  lower_limit_b;
        logic [7:0]  roof_code;
        logic [7:0]  lock_code;
        logic [6:0]  position_pct;
        logic        is_open;
        logic        is_lowered;
    } t_result;

endpackage

// ===== rtl/spd_front.sv =====
`include "assert_macros.svh"

module spd_front #(
    parameter int SYNC_LENGTH = spd_pkg::SYNC_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data,
    input  logic [7:0]          i_sync_value,
    output logic                o_push,
    output spd_pkg::t_entry     o_entry
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_SYNC    = 3'b010,
        ST_PAYLOAD = 3'b100
    } t_phase;

    localparam logic [spd_pkg::CNT_W-1:0] LAST_IDX =
        spd_pkg::CNT_W'(spd_pkg::PAYLOAD_LEN - 1);
    localparam logic [spd_pkg::CNT_W-1:0] LEN_CNT =
        spd_pkg::CNT_W'(spd_pkg::PAYLOAD_LEN);
    localparam logic [spd_pkg::SEEN_W-1:0] SYNC_NEED = spd_pkg::SEEN_W'(SYNC_LENGTH);

    t_phase                      r_phase, n_phase;
    logic [spd_pkg::SEEN_W-1:0]  r_seen, n_seen;
    logic [spd_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        w_match;

    assign w_match = (i_data == i_sync_value);

    // Classify the item and advance the hunt / collect state
    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        n_count = r_count;
        o_push  = 1'b0;
        o_entry.data = i_data;
        o_entry.idx  = r_count;
        o_entry.last = (r_count == LAST_IDX);
        if (i_accept) begin
            unique case (r_phase)
                ST_SYNC: begin
                    if (w_match) begin
                        n_seen  = r_seen + 1'b1;
                        n_count = '0;
                        n_phase = (n_seen >= SYNC_NEED) ? ST_PAYLOAD : ST_SYNC;
                    end else begin
                        n_phase = ST_IDLE;
                        n_seen  = '0;
                        n_count = '0;
                    end
                end
                ST_PAYLOAD: begin
                    if (r_count >= LEN_CNT || r_count == LAST_IDX) begin
                        o_push  = (r_count == LAST_IDX);
                        n_phase = ST_IDLE;
                        n_seen  = '0;
                        n_count = '0;
                    end else begin
                        o_push  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                default: begin
                    if (w_match) begin
                        n_seen  = spd_pkg::SEEN_W'(1);
                        n_count = '0;
                        n_phase = (n_seen >= SYNC_NEED) ? ST_PAYLOAD : ST_SYNC;
                    end else begin
                        n_phase = ST_IDLE;
                        n_seen  = '0;
                        n_count = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_IDLE;
            r_seen  <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_count <= n_count;
        end
    end

    // The last payload byte always ends the frame
    `SPD_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, o_push && o_entry.last, r_phase == ST_IDLE)

endmodule

// ===== rtl/spd_queue.sv =====
`include "assert_macros.svh"

module spd_queue #(
    parameter int DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output spd_pkg::t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    spd_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              w_push, w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SPD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)

endmodule

// ===== rtl/spd_back.sv =====
`include "assert_macros.svh"

module spd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  spd_pkg::t_entry  i_entry,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output spd_pkg::t_result o_result
);

    localparam int STORE_N = spd_pkg::PAYLOAD_LEN - 1;

    logic [7:0]       r_store [STORE_N];
    logic             r_valid;
    spd_pkg::t_result r_result, n_result;
    logic [7:0]       w_roof;

    // Take an item unless it closes a frame and the output slot is still busy
    assign o_pop = i_valid && (!i_entry.last || !r_valid || i_ready);

    // Store payload bytes by position
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORE_N; i++) begin
            if (o_pop && !i_entry.last && i_entry.idx == spd_pkg::CNT_W'(i)) begin
                r_store[i] <= i_entry.data;
            end
        end
    end

    // Assemble the packet from stored bytes plus the closing byte
    assign w_roof = r_store[16];
    always_comb begin
        n_result.current_bits  = {r_store[3], r_store[2], r_store[1], r_store[0]};
        n_result.supply5_bits  = {r_store[7], r_store[6], r_store[5], r_store[4]};
        n_result.supply12_bits = {r_store[11], r_store[10], r_store[9], r_store[8]};
        n_result.upper_limit_a = r_store[12];
        n_result.upper_limit_b = r_store[13];
        n_result.lower_limit_a = r_store[14];
        n_result.lower_limit_b = r_store[15];
        n_result.roof_code     = w_roof;
        n_result.lock_code     = i_entry.data;
        n_result.is_open       = (w_roof == spd_pkg::ROOF_RAISED);
        n_result.is_lowered    = (w_roof == spd_pkg::ROOF_LOWERED);
        unique case (w_roof) inside
            spd_pkg::ROOF_RAISED:   n_result.position_pct = spd_pkg::POS_RAISED;
            spd_pkg::ROOF_RAISING,
            spd_pkg::ROOF_LOWERING: n_result.position_pct = spd_pkg::POS_MOVING;
            default:                n_result.position_pct = spd_pkg::POS_OTHER;
        endcase
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_entry.last) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A closing byte never overwrites a result that is still waiting
    `SPD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_pop && i_entry.last && r_valid, i_ready)

endmodule

// ===== rtl/status_packet_deframer.sv =====
// Payload bytes pass through the front-to-back queue. The closing byte loads the
// output register when it is free or being read, and waits in the queue otherwise.
// Throughput: one byte per cycle while the queue is not full. A packet holds three
// sync bytes and 18 payload bytes; input ready is set by the fill of the queue.
// Reset (synchronous, active low): hunt restarts from idle, queue empties, output
// goes invalid, sync value returns to 80. Payload bytes are not cleared.
module status_packet_deframer #(
    parameter int SYNC_LENGTH = spd_pkg::SYNC_LEN_DEF,
    parameter int QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_current_bits,
    output logic [31:0] o_supply5_bits,
    output logic [31:0] o_supply12_bits,
    output logic [7:0]  o_upper_limit_a,
    output logic [7:0]  o_upper_limit_b,
    output logic [7:0]  o_lower_limit_a,
    output logic [7:0]  o_lower_limit_b,
    output logic [7:0]  o_roof_code,
    output logic [7:0]  o_lock_code,
    output logic [6:0]  o_position_pct,
    output logic        o_is_open,
    output logic        o_is_lowered
);

    logic [7:0]       r_sync_value;
    logic             w_full, w_accept, w_push, w_q_valid, w_pop;
    spd_pkg::t_entry  w_push_entry, w_q_entry;
    spd_pkg::t_result w_result;

    // Sync value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= spd_pkg::SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync_value <= i_cfg_wdata;
        end
    end

    assign o_ready  = !w_full;
    assign w_accept = i_valid && o_ready;

    spd_front #(
        .SYNC_LENGTH (SYNC_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data       (i_rx_byte),
        .i_sync_value (r_sync_value),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    spd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    spd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_entry  (w_q_entry),
        .o_pop    (w_pop),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (w_result)
    );

    // Break the result out to ports
    assign o_current_bits  = w_result.current_bits;
    assign o_supply5_bits  = w_result.supply5_bits;
    assign o_supply12_bits = w_result.supply12_bits;
    assign o_upper_limit_a = w_result.upper_limit_a;
    assign o_upper_limit_b = w_result.upper_limit_b;
    assign o_lower_limit_a = w_result.lower_limit_a;
    assign o_lower_limit_b = w_result.lower_limit_b;
    assign o_roof_code     = w_result.roof_code;
    assign o_lock_code     = w_result.lock_code;
    assign o_position_pct  = w_result.position_pct;
    assign o_is_open       = w_result.is_open;
    assign o_is_lowered    = w_result.is_lowered;

endmodule

// ===== test/status_packet_deframer_tb.sv =====
`timescale 1ns / 1ps

module status_packet_deframer_tb;

    localparam int HALF_PERIOD       = 2;
    localparam int RESET_CYCLES      = 5;
    localparam int SETTLE_CYCLES     = 8;
    localparam int STALL_LIMIT       = 2000;
    localparam int ITEMS_PER_SETTING = 105;
    localparam int GAP_PERCENT       = 28;

    typedef enum logic [1:0] {HUNT_IDLE, HUNT_SYNC, HUNT_PAYLOAD} t_hunt;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_current_bits;
    logic [31:0] o_supply5_bits;
    logic [31:0] o_supply12_bits;
    logic [7:0]  o_upper_limit_a;
    logic [7:0]  o_upper_limit_b;
    logic [7:0]  o_lower_limit_a;
    logic [7:0]  o_lower_limit_b;
    logic [7:0]  o_roof_code;
    logic [7:0]  o_lock_code;
    logic [6:0]  o_position_pct;
    logic        o_is_open;
    logic        o_is_lowered;

    // Deframer prediction state
    t_hunt                      hunt_state = HUNT_IDLE;
    logic [spd_pkg::SEEN_W-1:0] sync_count = '0;
    logic [spd_pkg::CNT_W-1:0]  pkt_count  = '0;
    logic [7:0]                 pkt_bytes [spd_pkg::PAYLOAD_LEN];
    logic [7:0]                 sync_cfg   = spd_pkg::SYNC_RESET;

    // Stimulus and scoreboard
    logic [7:0]       byte_q [$];
    spd_pkg::t_result status_q [$];
    int         issued_count   = 0;
    int         taken_count    = 0;
    int         queued_total   = 0;
    int         packets_seen   = 0;
    int         drain_pauses   = 0;
    int         settings_used  = 1;
    int         fail_count     = 0;
    int         stall_cycles   = 0;
    bit         no_gaps        = 1'b0;

    status_packet_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_current_bits (o_current_bits),
        .o_supply5_bits (o_supply5_bits),
        .o_supply12_bits(o_supply12_bits),
        .o_upper_limit_a(o_upper_limit_a),
        .o_upper_limit_b(o_upper_limit_b),
        .o_lower_limit_a(o_lower_limit_a),
        .o_lower_limit_b(o_lower_limit_b),
        .o_roof_code    (o_roof_code),
        .o_lock_code    (o_lock_code),
        .o_position_pct (o_position_pct),
        .o_is_open      (o_is_open),
        .o_is_lowered   (o_is_lowered)
    );

    // Free-running clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // Count one sync byte; enough of them opens the payload
    function automatic void bump_sync();
        sync_count = sync_count + 1'b1;
        if (sync_count >= spd_pkg::SYNC_LEN_DEF) begin
            hunt_state = HUNT_PAYLOAD;
            pkt_count  = '0;
        end else begin
            hunt_state = HUNT_SYNC;
        end
    endfunction

    function automatic void drop_to_idle();
        hunt_state = HUNT_IDLE;
        sync_count = '0;
        pkt_count  = '0;
    endfunction

    // Advance the deframer by one byte; queue the decoded packet when complete
    function automatic void deframe_byte(logic [7:0] b);
        spd_pkg::t_result pkt;
        logic [7:0] roof;
        case (hunt_state)
            HUNT_SYNC: begin
                if (b == sync_cfg) bump_sync();
                else drop_to_idle();
            end
            HUNT_PAYLOAD: begin
                if (pkt_count >= spd_pkg::PAYLOAD_LEN) begin
                    drop_to_idle();
                end else begin
                    pkt_bytes[pkt_count] = b;
                    pkt_count = pkt_count + 1'b1;
                    if (pkt_count == spd_pkg::PAYLOAD_LEN) begin
                        roof = pkt_bytes[16];
                        pkt.current_bits  = {pkt_bytes[3], pkt_bytes[2],
                                             pkt_bytes[1], pkt_bytes[0]};
                        pkt.supply5_bits  = {pkt_bytes[7], pkt_bytes[6],
                                             pkt_bytes[5], pkt_bytes[4]};
                        pkt.supply12_bits = {pkt_bytes[11], pkt_bytes[10],
                                             pkt_bytes[9], pkt_bytes[8]};
                        pkt.upper_limit_a = pkt_bytes[12];
                        pkt.upper_limit_b = pkt_bytes[13];
                        pkt.lower_limit_a = pkt_bytes[14];
                        pkt.lower_limit_b = pkt_bytes[15];
                        pkt.roof_code     = roof;
                        pkt.lock_code     = pkt_bytes[17];
                        if (roof == spd_pkg::ROOF_RAISED)
                            pkt.position_pct = spd_pkg::POS_RAISED;
                        else if (roof == spd_pkg::ROOF_RAISING ||
                                 roof == spd_pkg::ROOF_LOWERING)
                            pkt.position_pct = spd_pkg::POS_MOVING;
                        else
                            pkt.position_pct = spd_pkg::POS_OTHER;
                        pkt.is_open    = (roof == spd_pkg::ROOF_RAISED);
                        pkt.is_lowered = (roof == spd_pkg::ROOF_LOWERED);
                        status_q = {status_q, pkt};
                        drop_to_idle();
                    end
                end
            end
            default: begin
                if (b == sync_cfg) begin
                    sync_count = '0;
                    bump_sync();
                end else begin
                    drop_to_idle();
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Compare the item on the output against the oldest pending packet
    task automatic check_status();
        spd_pkg::t_result want;
        if (status_q.size() == 0) begin
            report_mismatch("result with nothing pending", {24'd0, o_roof_code}, 32'd0);
        end else begin
            want = status_q.pop_front();
            packets_seen++;
            if (o_current_bits !== want.current_bits)
                report_mismatch("current_bits", o_current_bits, want.current_bits);
            if (o_supply5_bits !== want.supply5_bits)
                report_mismatch("supply5_bits", o_supply5_bits, want.supply5_bits);
            if (o_supply12_bits !== want.supply12_bits)
                report_mismatch("supply12_bits", o_supply12_bits, want.supply12_bits);
            if (o_upper_limit_a !== want.upper_limit_a)
                report_mismatch("upper_limit_a", 32'(o_upper_limit_a),
                                32'(want.upper_limit_a));
            if (o_upper_limit_b !== want.upper_limit_b)
                report_mismatch("upper_limit_b", 32'(o_upper_limit_b),
                                32'(want.upper_limit_b));
            if (o_lower_limit_a !== want.lower_limit_a)
                report_mismatch("lower_limit_a", 32'(o_lower_limit_a),
                                32'(want.lower_limit_a));
            if (o_lower_limit_b !== want.lower_limit_b)
                report_mismatch("lower_limit_b", 32'(o_lower_limit_b),
                                32'(want.lower_limit_b));
            if (o_roof_code !== want.roof_code)
                report_mismatch("roof_code", 32'(o_roof_code), 32'(want.roof_code));
            if (o_lock_code !== want.lock_code)
                report_mismatch("lock_code", 32'(o_lock_code), 32'(want.lock_code));
            if (o_position_pct !== want.position_pct)
                report_mismatch("position_pct", 32'(o_position_pct),
                                32'(want.position_pct));
            if (o_is_open !== want.is_open)
                report_mismatch("is_open", 32'(o_is_open), 32'(want.is_open));
            if (o_is_lowered !== want.is_lowered)
                report_mismatch("is_lowered", 32'(o_is_lowered), 32'(want.is_lowered));
        end
    endtask

    // Sample handshakes at the rising edge: predict, check, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                taken_count <= taken_count + 1;
                deframe_byte(i_rx_byte);
            end
            if (o_valid && i_ready)
                check_status();
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAIL status_packet_deframer");
                $finish;
            end
        end
    end

    // Byte driver: hold the item until taken, then idle or present the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (taken_count == issued_count) begin
            if (byte_q.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
                i_rx_byte    <= byte_q.pop_front();
                i_valid      <= 1'b1;
                issued_count <= issued_count + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result sink: stall at random, never during the no-gaps stretch
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end

    task automatic queue_byte(input logic [7:0] b);
        byte_q = {byte_q, b};
        queued_total++;
    endtask

    // Three sync bytes and a random payload carrying the given roof code
    task automatic queue_packet(input logic [7:0] roof);
        logic [7:0] b;
        repeat (spd_pkg::SYNC_LEN_DEF) queue_byte(sync_cfg);
        for (int k = 0; k < spd_pkg::PAYLOAD_LEN; k++) begin
            if (k == 16)
                b = roof;
            else if ($urandom_range(7) == 0)
                b = sync_cfg;
            else
                b = 8'($urandom_range(255));
            queue_byte(b);
        end
    endtask

    // Line noise, often hitting the sync value
    task automatic queue_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) begin
            if ($urandom_range(3) == 0) queue_byte(sync_cfg);
            else queue_byte(8'($urandom_range(255)));
        end
    endtask

    // A sync run cut short by a foreign byte
    task automatic queue_broken_sync();
        int n;
        n = $urandom_range(2, 1);
        repeat (n) queue_byte(sync_cfg);
        queue_byte(sync_cfg + 8'($urandom_range(255, 1)));
    endtask

    // Hold the sender until every byte is taken and every packet has come out
    task automatic drain_all();
        while (byte_q.size() != 0 || taken_count != issued_count || status_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Change the sync value with the block quiet
    task automatic write_sync(input logic [7:0] value);
        drain_all();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sync_cfg = value;
        settings_used++;
    endtask

    task automatic run_random(input int n_items);
        int target;
        int pick;
        logic [7:0] roof;
        target = queued_total + n_items;
        while (queued_total < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                if ($urandom_range(9) < 7) roof = 8'($urandom_range(5));
                else roof = 8'($urandom_range(255));
                queue_packet(roof);
            end else if (pick < 88) begin
                queue_noise();
            end else begin
                queue_broken_sync();
            end
            if ($urandom_range(11) == 0) begin
                drain_all();
                drain_pauses++;
            end
        end
    endtask

    initial begin
        logic [7:0] b;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one packet of extreme bytes with the sync value inside the
        // payload and a roof code above the known range, then a broken hunt
        repeat (spd_pkg::SYNC_LEN_DEF) queue_byte(sync_cfg);
        for (int k = 0; k < spd_pkg::PAYLOAD_LEN; k++) begin
            case (k % 3)
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = sync_cfg;
            endcase
            queue_byte(b);
        end
        queue_byte(sync_cfg);
        queue_byte(sync_cfg);
        queue_byte(8'h00);

        // Random traffic under several sync values, one stretch without gaps
        run_random(ITEMS_PER_SETTING);
        write_sync(8'h00);
        no_gaps = 1'b1;
        run_random(ITEMS_PER_SETTING);
        write_sync(8'hFF);
        no_gaps = 1'b0;
        run_random(ITEMS_PER_SETTING);
        write_sync(8'($urandom_range(255)));
        run_random(ITEMS_PER_SETTING);
        write_sync(spd_pkg::SYNC_RESET);
        run_random(ITEMS_PER_SETTING);

        drain_all();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (status_q.size() != 0)
            report_mismatch("packets never delivered", 32'(status_q.size()), 32'd0);

        $display("Sent %0d bytes under %0d sync values, %0d sender drain pauses.",
                 queued_total, settings_used, drain_pauses);
        $display("Checked %0d decoded packets field by field, %0d mismatches.",
                 packets_seen, fail_count);
        if (fail_count == 0)
            $display("PASS status_packet_deframer");
        else
            $display("FAIL status_packet_deframer");
        $finish;
    end

endmodule
